FILE: rtl/md5_pkg.sv
`timescale 1ns / 1ps

package md5_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned CountW  = 3;
  localparam int unsigned LenW    = 61;
  localparam int unsigned Rounds  = 64;
  localparam int unsigned BlkWords = 16;

  localparam logic [WordW-1:0] InitA = 32'h67452301;
  localparam logic [WordW-1:0] InitB = 32'hefcdab89;
  localparam logic [WordW-1:0] InitC = 32'h98badcfe;
  localparam logic [WordW-1:0] InitD = 32'h10325476;

  // Additive constant of each round
  function automatic logic [WordW-1:0] sine_k(input logic [5:0] r);
    logic [WordW-1:0] k;
    case (r)
      6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
      6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
      6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
      6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
      default: k = '0;
    endcase
    return k;
  endfunction

  // Rotate amount, indexed by {group, round[1:0]}
  function automatic logic [4:0] rot_amt(input logic [3:0] sel);
    logic [4:0] s;
    case (sel)
      4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
      4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
      4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
      4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  4'd15: s = 5'd21;
      default: s = '0;
    endcase
    return s;
  endfunction

endpackage

FILE: rtl/md5_hash_engine_unit.sv
`timescale 1ns / 1ps
// MD5 digest engine.
// Input channel (in_*): one message word per transaction, first byte in bits 7:0.
//   in_tuser carries the valid byte count (read on the last word only, 5..7 act
//   as 4) and in_tlast marks the final word of the message.
// Output channel (out_*): four digest words A, B, C, D, out_tlast on D.
// Words are stored in a 16-entry block buffer. On the sixteenth word the block
// goes through the round unit, one MD5 round per cycle, then is added into the
// chaining value. in_tready is low meanwhile, so no word is taken until then.
// On the last word the pad byte, zero fill and 64-bit bit length are pushed
// one word per cycle, with one or two more compressions as needed; the digest
// then appears one word per cycle while out_tready is high. A stalled receiver
// holds the digest on the port and keeps in_tready low. Once D is taken the
// chaining value returns to the standard initial words for the next message.
// Reset (rst_n low, synchronous) clears all control state and loads the
// initial chaining value; no clearing pass is needed.
module md5_hash_engine_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [md5_pkg::WordW-1:0]           in_tdata,   // [31:0] data_word
  input  logic [md5_pkg::CountW-1:0]          in_tuser,   // [2:0] byte_count
  input  logic                                in_tlast,   // last_word
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [md5_pkg::WordW-1:0]           out_tdata,  // [31:0] digest_word
  output logic                                out_tlast   // digest_last
);
  import md5_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_ADD,
    ST_PAD,
    ST_OUT
  } state_t;

  state_t             state_r;
  logic [WordW-1:0]   cv_r [4];
  logic [WordW-1:0]   wa_r, wb_r, wc_r, wd_r;
  logic [WordW-1:0]   blk_r [BlkWords];
  logic [3:0]         pos_r;
  logic [LenW-1:0]    count_r;
  logic [5:0]         round_r;
  logic [1:0]         oidx_r;
  logic               msg_end_r;
  logic               pend_80_r;
  logic               len_lo_r;
  logic               done_r;

  logic               in_acc, out_acc;
  logic               push_en;
  logic [WordW-1:0]   push_word;
  logic [CountW-1:0]  cnt_sat;
  logic [WordW-1:0]   tail_word;
  logic [1:0]         grp;
  logic [3:0]         idx;
  logic [WordW-1:0]   mix, t_sum;
  logic [2*WordW-1:0] rot_dbl;
  logic [WordW-1:0]   b_nxt;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = (state_r == ST_OUT);
  assign out_acc    = out_tvalid && out_tready;
  assign out_tdata  = cv_r[oidx_r];
  assign out_tlast  = (oidx_r == 2'd3);

  // Final word: keep the valid bytes and place the pad byte after them
  always_comb begin
    cnt_sat = (in_tuser > CountW'(4)) ? CountW'(4) : in_tuser;
    case (cnt_sat[1:0])
      2'd0:    tail_word = 32'h0000_0080;
      2'd1:    tail_word = {16'h0000, 8'h80, in_tdata[7:0]};
      2'd2:    tail_word = {8'h00, 8'h80, in_tdata[15:0]};
      2'd3:    tail_word = {8'h80, in_tdata[23:0]};
      default: tail_word = 32'h0000_0080;
    endcase
  end

  always_comb begin
    push_en   = 1'b0;
    push_word = '0;
    if (in_acc) begin
      push_en   = 1'b1;
      push_word = (!in_tlast || cnt_sat[2]) ? in_tdata : tail_word;
    end else if (state_r == ST_PAD) begin
      push_en = 1'b1;
      if (pend_80_r) begin
        push_word = 32'h0000_0080;
      end else if (pos_r == 4'd14) begin
        push_word = {count_r[28:0], 3'b000};
      end else if (pos_r == 4'd15 && len_lo_r) begin
        push_word = count_r[LenW-1:29];
      end
    end
  end

  // Shared round unit
  always_comb begin
    grp = round_r[5:4];
    case (grp)
      2'd0: begin
        mix = (wb_r & wc_r) | (~wb_r & wd_r);
        idx = round_r[3:0];
      end
      2'd1: begin
        mix = (wd_r & wb_r) | (wc_r & ~wd_r);
        idx = {round_r[1:0], 2'b00} + round_r[3:0] + 4'd1;
      end
      2'd2: begin
        mix = wb_r ^ wc_r ^ wd_r;
        idx = {round_r[2:0], 1'b0} + round_r[3:0] + 4'd5;
      end
      default: begin
        mix = wc_r ^ (wb_r | ~wd_r);
        idx = {round_r[0], 3'b000} - round_r[3:0];
      end
    endcase
    t_sum   = wa_r + mix + sine_k(round_r) + blk_r[idx];
    rot_dbl = {t_sum, t_sum} << rot_amt({grp, round_r[1:0]});
    b_nxt   = wb_r + rot_dbl[2*WordW-1:WordW];
  end

  always_ff @(posedge clk) begin
    if (push_en) begin
      blk_r[pos_r] <= push_word;
    end
    if (push_en && pos_r == 4'd15) begin
      wa_r <= cv_r[0];
      wb_r <= cv_r[1];
      wc_r <= cv_r[2];
      wd_r <= cv_r[3];
    end else if (state_r == ST_ROUND) begin
      wa_r <= wd_r;
      wb_r <= b_nxt;
      wc_r <= wb_r;
      wd_r <= wc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      cv_r[0]   <= InitA;
      cv_r[1]   <= InitB;
      cv_r[2]   <= InitC;
      cv_r[3]   <= InitD;
      pos_r     <= '0;
      count_r   <= '0;
      round_r   <= '0;
      oidx_r    <= '0;
      msg_end_r <= 1'b0;
      pend_80_r <= 1'b0;
      len_lo_r  <= 1'b0;
      done_r    <= 1'b0;
    end else begin
      if (push_en) begin
        pos_r <= pos_r + 4'd1;
      end
      if (in_acc) begin
        count_r <= count_r + (in_tlast ? LenW'(cnt_sat) : LenW'(4));
        if (in_tlast) begin
          msg_end_r <= 1'b1;
          pend_80_r <= cnt_sat[2];
        end
      end
      if (state_r == ST_PAD) begin
        pend_80_r <= 1'b0;
        if (!pend_80_r && pos_r == 4'd14) begin
          len_lo_r <= 1'b1;
        end
        if (!pend_80_r && pos_r == 4'd15 && len_lo_r) begin
          done_r <= 1'b1;
        end
      end

      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            if (pos_r == 4'd15) begin
              state_r <= ST_ROUND;
              round_r <= '0;
            end else if (in_tlast) begin
              state_r <= ST_PAD;
            end
          end
        end
        ST_PAD: begin
          if (pos_r == 4'd15) begin
            state_r <= ST_ROUND;
            round_r <= '0;
          end
        end
        ST_ROUND: begin
          round_r <= round_r + 6'd1;
          if (round_r == 6'(Rounds - 1)) begin
            state_r <= ST_ADD;
          end
        end
        ST_ADD: begin
          cv_r[0] <= cv_r[0] + wa_r;
          cv_r[1] <= cv_r[1] + wb_r;
          cv_r[2] <= cv_r[2] + wc_r;
          cv_r[3] <= cv_r[3] + wd_r;
          if (done_r) begin
            state_r <= ST_OUT;
            oidx_r  <= '0;
          end else if (msg_end_r) begin
            state_r <= ST_PAD;
          end else begin
            state_r <= ST_IDLE;
          end
        end
        ST_OUT: begin
          if (out_acc) begin
            oidx_r <= oidx_r + 2'd1;
            if (out_tlast) begin
              // digest delivered: start afresh for the next message
              state_r   <= ST_IDLE;
              cv_r[0]   <= InitA;
              cv_r[1]   <= InitB;
              cv_r[2]   <= InitC;
              cv_r[3]   <= InitD;
              pos_r     <= '0;
              count_r   <= '0;
              msg_end_r <= 1'b0;
              pend_80_r <= 1'b0;
              len_lo_r  <= 1'b0;
              done_r    <= 1'b0;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input taken while digest pending");

  a_last_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_tlast |=> !in_tready)
    else $error("input still open after last word");

  a_round_end: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_ROUND && round_r == 6'(Rounds - 1) |=> state_r == ST_ADD)
    else $error("round sequence overran");

  a_pad_in_msg: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_PAD |-> msg_end_r)
    else $error("padding outside a message end");

  a_clean_restart: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && out_tlast |=> pos_r == 4'd0 && count_r == '0 && !done_r)
    else $error("state not cleared after digest");

endmodule
